// ===== rtl/rbpl_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpl_pkg
// Shared types, codes and defaults of the refcounted block pool with LRU.
// ----------------------------------------------------------------------------
package rbpl_pkg;

  // Default sizes
  localparam int POOL_SIZE_DEF  = 1024;
  localparam int REF_WIDTH_DEF  = 16;
  localparam int HASH_WIDTH_DEF = 64;

  // Fixed port field widths
  localparam int FUNC_W = 2;
  localparam int ID_W   = 10;
  localparam int HASH_W = 64;
  localparam int ST_W   = 3;
  localparam int CNT_W  = 11;

  // Request kinds
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_HIT     = 2'd1;
  localparam logic [FUNC_W-1:0] FN_MARK    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK           = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_ID       = 3'd1;
  localparam logic [ST_W-1:0] ST_EXHAUSTED    = 3'd2;
  localparam logic [ST_W-1:0] ST_DOUBLE_FREE  = 3'd3;
  localparam logic [ST_W-1:0] ST_INCONSISTENT = 3'd4;

  // Block flag bits
  localparam int FB_FREE   = 0;
  localparam int FB_CACHED = 1;
  localparam int FB_LRU    = 2;
  localparam logic [2:0] FLAGS_FREE = 3'b001;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   blk_id;
    logic [HASH_W-1:0] content_hash;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  granted_id;
    logic             evicted;
    logic [ID_W-1:0]  evicted_id;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] idle_count;
  } rsp_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_TGT_LRU,
    OP_TGT_FIFO,
    OP_UNLINK,
    OP_EVICT,
    OP_GRANT,
    OP_HIT_IDLE,
    OP_HIT_INC,
    OP_MARK,
    OP_REL,
    OP_PUSH2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            st_we;
    logic [ST_W-1:0] st;
    logic            emit;
  } cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic [FUNC_W-1:0] func;
    logic              id_bad;
    logic              free_empty;
    logic              lru_empty;
    logic              ev_ok;
    logic              al_id_bad;
    logic              al_ok;
    logic              hit_bad;
    logic              hit_idle;
    logic              hit_act;
    logic              ref_max;
    logic              mark_bad;
    logic              hash_eq;
    logic              is_free;
    logic              is_lru;
    logic              cached;
    logic              ref_zero;
    logic              rel_last;
    logic              out_busy;
  } sts_t;

endpackage

// ===== rtl/rbpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbpl_ctrl
// Sequencer: steps each request through reads, checks and memory updates.
// ----------------------------------------------------------------------------
module rbpl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rbpl_pkg::sts_t sts_i,
  output rbpl_pkg::cmd_t cmd_o
);
  import rbpl_pkg::*;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_EV_WAIT = 4'd3;
  localparam logic [3:0] S_EV_CHK  = 4'd4;
  localparam logic [3:0] S_EV_DO   = 4'd5;
  localparam logic [3:0] S_AL_TGT  = 4'd6;
  localparam logic [3:0] S_AL_SEL  = 4'd7;
  localparam logic [3:0] S_AL_WAIT = 4'd8;
  localparam logic [3:0] S_AL_CHK  = 4'd9;
  localparam logic [3:0] S_CHK     = 4'd10;
  localparam logic [3:0] S_HIT_DO  = 4'd11;
  localparam logic [3:0] S_PUSH2   = 4'd12;
  localparam logic [3:0] S_RESP    = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, st_we: 1'b0, st: ST_OK, emit: 1'b0};
    case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.func == FN_ALLOC) begin
          if (!sts_i.free_empty) begin
            state_d = S_AL_TGT;
          end else if (sts_i.lru_empty) begin
            cmd_o.st_we = 1'b1;
            cmd_o.st    = ST_EXHAUSTED;
            state_d     = S_RESP;
          end else begin
            cmd_o.op = OP_TGT_LRU;
            state_d  = S_EV_WAIT;
          end
        end else if (sts_i.id_bad) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_BAD_ID;
          state_d     = S_RESP;
        end else begin
          state_d = S_CHK;
        end
      end
      S_EV_WAIT: state_d = S_EV_CHK;
      S_EV_CHK: begin
        if (!sts_i.ev_ok) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_EXHAUSTED;
          state_d     = S_RESP;
        end else begin
          cmd_o.op = OP_UNLINK;
          state_d  = S_EV_DO;
        end
      end
      S_EV_DO: begin
        cmd_o.op = OP_EVICT;
        state_d  = S_AL_TGT;
      end
      // let the free FIFO read settle after a push
      S_AL_TGT: state_d = S_AL_SEL;
      S_AL_SEL: begin
        if (sts_i.al_id_bad) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_INCONSISTENT;
          state_d     = S_RESP;
        end else begin
          cmd_o.op = OP_TGT_FIFO;
          state_d  = S_AL_WAIT;
        end
      end
      S_AL_WAIT: state_d = S_AL_CHK;
      S_AL_CHK: begin
        cmd_o.st_we = 1'b1;
        if (sts_i.al_ok) begin
          cmd_o.op = OP_GRANT;
          cmd_o.st = ST_OK;
        end else begin
          cmd_o.st = ST_INCONSISTENT;
        end
        state_d = S_RESP;
      end
      S_CHK: begin
        cmd_o.st_we = 1'b1;
        state_d     = S_RESP;
        case (sts_i.func)
          FN_HIT: begin
            if (sts_i.hit_bad) begin
              cmd_o.st = ST_INCONSISTENT;
            end else if (sts_i.hit_idle) begin
              cmd_o.op = OP_UNLINK;
              cmd_o.st = ST_OK;
              state_d  = S_HIT_DO;
            end else if (sts_i.hit_act && !sts_i.ref_max) begin
              cmd_o.op = OP_HIT_INC;
              cmd_o.st = ST_OK;
            end else begin
              cmd_o.st = ST_INCONSISTENT;
            end
          end
          FN_MARK: begin
            if (sts_i.mark_bad) begin
              cmd_o.st = ST_INCONSISTENT;
            end else if (sts_i.cached) begin
              cmd_o.st = sts_i.hash_eq ? ST_OK : ST_INCONSISTENT;
            end else begin
              cmd_o.op = OP_MARK;
              cmd_o.st = ST_OK;
            end
          end
          FN_RELEASE: begin
            if (sts_i.is_free || (!sts_i.is_lru && sts_i.ref_zero)) begin
              cmd_o.st = ST_DOUBLE_FREE;
            end else if (sts_i.is_lru) begin
              cmd_o.st = ST_INCONSISTENT;
            end else begin
              cmd_o.op = OP_REL;
              cmd_o.st = ST_OK;
              if (sts_i.rel_last && sts_i.cached) state_d = S_PUSH2;
            end
          end
          default: cmd_o.st = ST_INCONSISTENT;
        endcase
      end
      S_HIT_DO: begin
        cmd_o.op = OP_HIT_IDLE;
        state_d  = S_RESP;
      end
      S_PUSH2: begin
        cmd_o.op = OP_PUSH2;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rbpl_dp.sv =====
// ----------------------------------------------------------------------------
// rbpl_dp
// Datapath: per-block memories, free FIFO, LRU links and the result register.
// ----------------------------------------------------------------------------
module rbpl_dp #(
  parameter int POOL_SIZE  = rbpl_pkg::POOL_SIZE_DEF,
  parameter int REF_WIDTH  = rbpl_pkg::REF_WIDTH_DEF,
  parameter int HASH_WIDTH = rbpl_pkg::HASH_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rbpl_pkg::req_t in_data_i,
  input  rbpl_pkg::cmd_t cmd_i,
  output rbpl_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rbpl_pkg::rsp_t out_data_o
);
  import rbpl_pkg::*;

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int SW = $clog2(2 * POOL_SIZE);
  localparam logic [LW-1:0] LNULL = LW'(POOL_SIZE);
  localparam logic [LW-1:0] NMAX  = LW'(POOL_SIZE);

  // Memories
  logic [REF_WIDTH-1:0]  ref_mem  [POOL_SIZE];
  logic [2:0]            flag_mem [POOL_SIZE];
  logic [HASH_WIDTH-1:0] hash_mem [POOL_SIZE];
  logic [IW-1:0]         fifo_mem [POOL_SIZE];
  logic [LW-1:0]         prev_mem [POOL_SIZE];
  logic [LW-1:0]         next_mem [POOL_SIZE];

  // Read data
  logic [REF_WIDTH-1:0]  ref_rd_q;
  logic [2:0]            flg_rd_q;
  logic [HASH_WIDTH-1:0] hsh_rd_q;
  logic [IW-1:0]         fifo_rd_q;
  logic [LW-1:0]         prv_rd_q, nxt_rd_q;

  // Item and list control
  logic [FUNC_W-1:0]     func_q;
  logic [ID_W-1:0]       id_q;
  logic [HASH_WIDTH-1:0] hash_q;
  logic [IW-1:0]         tgt_q, clr_q;
  logic [IW-1:0]         free_head_q, free_head_d;
  logic [LW-1:0]         free_cnt_q, free_cnt_d;
  logic [LW-1:0]         lru_head_q, lru_head_d, lru_tail_q, lru_tail_d;
  logic [LW-1:0]         lru_cnt_q, lru_cnt_d;

  // Result under construction
  logic [ST_W-1:0] res_st_q;
  logic [ID_W-1:0] res_gid_q, res_evid_q;
  logic            res_ev_q;
  logic            out_valid_q;
  rsp_t            out_q;

  // Memory write ports
  logic                  ref_we, flg_we, hsh_we, fifo_we, prv_we, nxt_we;
  logic [IW-1:0]         ref_wa, flg_wa, hsh_wa, fifo_wa, prv_wa, nxt_wa;
  logic [REF_WIDTH-1:0]  ref_wd;
  logic [2:0]            flg_wd;
  logic [HASH_WIDTH-1:0] hsh_wd;
  logic [IW-1:0]         fifo_wd;
  logic [LW-1:0]         prv_wd, nxt_wd;

  logic          p_ok, n_ok, t_ok;
  logic          rel_last, push_lru, push_free, free_full;
  logic [SW-1:0] slot_sum;
  logic [IW-1:0] slot;

  function automatic logic [2:0] FLAGS_LRU_MASK();
    logic [2:0] m;
    m = '0;
    m[FB_LRU] = 1'b1;
    return m;
  endfunction

  function automatic logic [2:0] FLAGS_CACHED_MASK();
    logic [2:0] m;
    m = '0;
    m[FB_CACHED] = 1'b1;
    return m;
  endfunction

  assign p_ok      = (prv_rd_q < LNULL);
  assign n_ok      = (nxt_rd_q < LNULL);
  assign t_ok      = (lru_tail_q < LNULL);
  assign rel_last  = (ref_rd_q == REF_WIDTH'(1));
  assign push_lru  = (cmd_i.op == OP_REL) && rel_last && flg_rd_q[FB_CACHED];
  assign push_free = (cmd_i.op == OP_EVICT) ||
                     ((cmd_i.op == OP_REL) && rel_last && !flg_rd_q[FB_CACHED]);
  assign free_full = (free_cnt_q >= NMAX);

  // Free FIFO tail slot, head plus count wrapped once
  assign slot_sum = SW'(free_head_q) + SW'(free_cnt_q);
  assign slot     = (slot_sum >= SW'(POOL_SIZE)) ? IW'(slot_sum - SW'(POOL_SIZE))
                                                 : IW'(slot_sum);

  // Memory write selection
  always_comb begin
    ref_we = 1'b0; ref_wa = tgt_q; ref_wd = '0;
    flg_we = 1'b0; flg_wa = tgt_q; flg_wd = FLAGS_FREE;
    hsh_we = 1'b0; hsh_wa = tgt_q; hsh_wd = '0;
    fifo_we = 1'b0; fifo_wa = slot; fifo_wd = tgt_q;
    prv_we = 1'b0; prv_wa = tgt_q; prv_wd = LNULL;
    nxt_we = 1'b0; nxt_wa = tgt_q; nxt_wd = LNULL;
    case (cmd_i.op)
      OP_CLEAR: begin
        ref_we = 1'b1; ref_wa = clr_q;
        flg_we = 1'b1; flg_wa = clr_q;
        hsh_we = 1'b1; hsh_wa = clr_q;
        fifo_we = 1'b1; fifo_wa = clr_q; fifo_wd = clr_q;
        prv_we = 1'b1; prv_wa = clr_q;
        nxt_we = 1'b1; nxt_wa = clr_q;
      end
      OP_UNLINK: begin
        // bypass the target: next of prev and prev of next
        prv_we = n_ok; prv_wa = IW'(nxt_rd_q); prv_wd = prv_rd_q;
        nxt_we = p_ok; nxt_wa = IW'(prv_rd_q); nxt_wd = nxt_rd_q;
      end
      OP_EVICT: begin
        flg_we = 1'b1;
        hsh_we = 1'b1;
        fifo_we = !free_full;
        prv_we = 1'b1;
        nxt_we = 1'b1;
      end
      OP_GRANT: begin
        ref_we = 1'b1; ref_wd = REF_WIDTH'(1);
        flg_we = 1'b1; flg_wd = '0;
        hsh_we = 1'b1;
      end
      OP_HIT_IDLE: begin
        ref_we = 1'b1; ref_wd = REF_WIDTH'(1);
        flg_we = 1'b1; flg_wd = flg_rd_q & ~FLAGS_LRU_MASK();
        prv_we = 1'b1;
        nxt_we = 1'b1;
      end
      OP_HIT_INC: begin
        ref_we = 1'b1; ref_wd = ref_rd_q + REF_WIDTH'(1);
      end
      OP_MARK: begin
        flg_we = 1'b1; flg_wd = flg_rd_q | FLAGS_CACHED_MASK();
        hsh_we = 1'b1; hsh_wd = hash_q;
      end
      OP_REL: begin
        ref_we = 1'b1; ref_wd = ref_rd_q - REF_WIDTH'(1);
        if (push_lru) begin
          flg_we = 1'b1; flg_wd = flg_rd_q | FLAGS_LRU_MASK();
          prv_we = 1'b1; prv_wd = lru_tail_q;
          nxt_we = 1'b1;
        end else if (push_free) begin
          flg_we = 1'b1;
          hsh_we = 1'b1;
          fifo_we = !free_full;
        end
      end
      OP_PUSH2: begin
        nxt_we = t_ok; nxt_wa = IW'(lru_tail_q); nxt_wd = LW'(tgt_q);
      end
      default: ;
    endcase
  end

  // Memory ports: one write, registered read at the target (the free FIFO reads at its head)
  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_wa] <= ref_wd;
    ref_rd_q <= ref_mem[tgt_q];
  end

  always_ff @(posedge clk_i) begin
    if (flg_we) flag_mem[flg_wa] <= flg_wd;
    flg_rd_q <= flag_mem[tgt_q];
  end

  always_ff @(posedge clk_i) begin
    if (hsh_we) hash_mem[hsh_wa] <= hsh_wd;
    hsh_rd_q <= hash_mem[tgt_q];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    fifo_rd_q <= fifo_mem[free_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prev_mem[prv_wa] <= prv_wd;
    prv_rd_q <= prev_mem[tgt_q];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
    nxt_rd_q <= next_mem[tgt_q];
  end

  // List head, tail and counts
  always_comb begin
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    lru_head_d  = lru_head_q;
    lru_tail_d  = lru_tail_q;
    lru_cnt_d   = lru_cnt_q;
    if (push_free && !free_full) free_cnt_d = free_cnt_q + LW'(1);
    case (cmd_i.op)
      OP_UNLINK: begin
        if (!p_ok) lru_head_d = nxt_rd_q;
        if (!n_ok) lru_tail_d = prv_rd_q;
      end
      OP_EVICT, OP_HIT_IDLE: begin
        if (lru_cnt_q != '0) lru_cnt_d = lru_cnt_q - LW'(1);
      end
      OP_GRANT: begin
        free_head_d = (free_head_q == IW'(POOL_SIZE - 1)) ? '0 : free_head_q + IW'(1);
        free_cnt_d  = free_cnt_q - LW'(1);
      end
      OP_PUSH2: begin
        if (!t_ok) lru_head_d = LW'(tgt_q);
        lru_tail_d = LW'(tgt_q);
        lru_cnt_d  = lru_cnt_q + LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_cnt_q  <= NMAX;
      lru_head_q  <= LNULL;
      lru_tail_q  <= LNULL;
      lru_cnt_q   <= '0;
      clr_q       <= '0;
    end else begin
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      lru_head_q  <= lru_head_d;
      lru_tail_q  <= lru_tail_d;
      lru_cnt_q   <= lru_cnt_d;
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + IW'(1);
    end
  end

  // Item fields, target and result under construction
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q     <= in_data_i.func;
        id_q       <= in_data_i.blk_id;
        hash_q     <= HASH_WIDTH'(in_data_i.content_hash);
        tgt_q      <= IW'(in_data_i.blk_id);
        res_gid_q  <= (in_data_i.func == FN_ALLOC) ? '0 : in_data_i.blk_id;
        res_ev_q   <= 1'b0;
        res_evid_q <= '0;
      end
      OP_TGT_LRU:  tgt_q <= IW'(lru_head_q);
      OP_TGT_FIFO: tgt_q <= fifo_rd_q;
      OP_EVICT: begin
        res_ev_q   <= 1'b1;
        res_evid_q <= ID_W'(tgt_q);
      end
      OP_GRANT: res_gid_q <= ID_W'(tgt_q);
      default: ;
    endcase
    if (cmd_i.st_we) res_st_q <= cmd_i.st;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status     <= res_st_q;
      out_q.granted_id <= res_gid_q;
      out_q.evicted    <= res_ev_q;
      out_q.evicted_id <= res_evid_q;
      out_q.free_count <= CNT_W'(free_cnt_q);
      out_q.idle_count <= CNT_W'(lru_cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the target block
  always_comb begin
    sts_o.clr_done   = (clr_q == IW'(POOL_SIZE - 1));
    sts_o.func       = func_q;
    sts_o.id_bad     = (32'(id_q) >= POOL_SIZE);
    sts_o.free_empty = (free_cnt_q == '0);
    sts_o.lru_empty  = !(lru_head_q < LNULL);
    sts_o.ev_ok      = flg_rd_q[FB_CACHED] && flg_rd_q[FB_LRU] && !flg_rd_q[FB_FREE] &&
                       (ref_rd_q == '0);
    sts_o.al_id_bad  = (LW'(fifo_rd_q) >= LNULL);
    sts_o.al_ok      = (flg_rd_q == FLAGS_FREE) && (ref_rd_q == '0) && (hsh_rd_q == '0);
    sts_o.hit_bad    = !flg_rd_q[FB_CACHED] || flg_rd_q[FB_FREE] || (hsh_rd_q != hash_q);
    sts_o.hit_idle   = flg_rd_q[FB_LRU] && (ref_rd_q == '0);
    sts_o.hit_act    = !flg_rd_q[FB_LRU] && (ref_rd_q != '0);
    sts_o.ref_max    = &ref_rd_q;
    sts_o.mark_bad   = (ref_rd_q == '0) || flg_rd_q[FB_FREE] || flg_rd_q[FB_LRU];
    sts_o.hash_eq    = (hsh_rd_q == hash_q);
    sts_o.is_free    = flg_rd_q[FB_FREE];
    sts_o.is_lru     = flg_rd_q[FB_LRU];
    sts_o.cached     = flg_rd_q[FB_CACHED];
    sts_o.ref_zero   = (ref_rd_q == '0);
    sts_o.rel_last   = rel_last;
    sts_o.out_busy   = out_valid_q && out_stall_i;
  end

endmodule

// ===== rtl/refcounted_block_pool_lru_unit.sv =====
// Each request steps through sequencer states that wait on the registered memory reads: a
// bad id or an empty pool is answered from dispatch; hit, mark and release pass a check
// step, with an extra step when a block joins or leaves the LRU list; allocate runs the free
// FIFO steps, after eviction steps when the free FIFO is empty. One item at a time: the next
// item is taken in idle, after the result enters the output register, which waits on a
// stalled result. After reset a clearing pass writes all memories; no item is taken then.
// ----------------------------------------------------------------------------
// refcounted_block_pool_lru_unit
// Reference counted block pool with a free FIFO and LRU eviction.
// ----------------------------------------------------------------------------
module refcounted_block_pool_lru_unit #(
  parameter int POOL_SIZE  = rbpl_pkg::POOL_SIZE_DEF,
  parameter int REF_WIDTH  = rbpl_pkg::REF_WIDTH_DEF,
  parameter int HASH_WIDTH = rbpl_pkg::HASH_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rbpl_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rbpl_pkg::rsp_t out_data_o
);
  import rbpl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rbpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Memories and list state
  rbpl_dp #(
    .POOL_SIZE  (POOL_SIZE),
    .REF_WIDTH  (REF_WIDTH),
    .HASH_WIDTH (HASH_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/rbpl_chk.sv =====
// ----------------------------------------------------------------------------
// rbpl_chk
// Port-level checks of the block pool, bound to the top level.
// ----------------------------------------------------------------------------
module rbpl_chk #(
  parameter int POOL_SIZE = rbpl_pkg::POOL_SIZE_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rbpl_pkg::rsp_t out_data_o
);
  import rbpl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // free and idle blocks never exceed the pool
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.free_count) + 32'(out_data_o.idle_count)
                     <= POOL_SIZE))
    else $error("free plus idle exceeds pool size");

  // a successful allocate with eviction leaves the free FIFO empty
  a_evict_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted && (out_data_o.status == ST_OK)
      |-> (out_data_o.free_count == '0))
    else $error("eviction with free blocks left");

  // no evicted id without an eviction
  a_evict_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.evicted |-> (out_data_o.evicted_id == '0))
    else $error("evicted id without eviction");

  // no item is taken while a request is in progress
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted during a request");

endmodule

bind refcounted_block_pool_lru_unit rbpl_chk #(.POOL_SIZE(POOL_SIZE)) u_rbpl_chk (.*);

// ===== tb/sv/pool_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_checker
// Watches both channels of the block pool, keeps its own model of the pool
// state, predicts the response of every accepted request and compares it.
// ----------------------------------------------------------------------------
module pool_checker
  import rbpl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_stall_i,
  input  req_t  in_data_i,
  input  logic  out_valid_i,
  input  logic  out_stall_i,
  input  rsp_t  out_data_i,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int NB = POOL_SIZE_DEF;
  localparam int NULL_ID = NB;
  localparam int REF_TOP = (1 << REF_WIDTH_DEF) - 1;

  int unsigned refs [NB];
  logic [2:0]  flags [NB];
  logic [63:0] hashes [NB];
  int unsigned fifo_ids [NB];
  int unsigned fifo_head, fifo_cnt;
  int unsigned prv [NB];
  int unsigned nxt [NB];
  int unsigned lru_head, lru_tail, lru_cnt;
  rsp_t        pending_rsp [$];

  task automatic pool_reset();
    for (int i = 0; i < NB; i++) begin
      refs[i] = 0; flags[i] = FLAGS_FREE; hashes[i] = '0; fifo_ids[i] = i;
      prv[i] = NULL_ID; nxt[i] = NULL_ID;
    end
    fifo_head = 0; fifo_cnt = NB;
    lru_head = NULL_ID; lru_tail = NULL_ID; lru_cnt = 0;
  endtask

  function automatic void fifo_push(int unsigned id);
    if (fifo_cnt >= NB) return;
    fifo_ids[(fifo_head + fifo_cnt) % NB] = id;
    fifo_cnt++;
  endfunction

  function automatic void lru_append(int unsigned id);
    prv[id] = lru_tail; nxt[id] = NULL_ID;
    if (lru_tail < NULL_ID) nxt[lru_tail] = id;
    else lru_head = id;
    lru_tail = id;
    lru_cnt++;
  endfunction

  function automatic void lru_remove(int unsigned id);
    int unsigned p, n;
    p = prv[id]; n = nxt[id];
    if (p < NULL_ID) nxt[p] = n; else lru_head = n;
    if (n < NULL_ID) prv[n] = p; else lru_tail = p;
    prv[id] = NULL_ID; nxt[id] = NULL_ID;
    if (lru_cnt > 0) lru_cnt--;
  endfunction

  // Apply one request to the pool model and return the response it gives
  function automatic rsp_t pool_serve(req_t rq);
    rsp_t r;
    int unsigned id, h, g;
    logic [2:0] f;
    bit ok;
    r = '0;
    id = 32'(rq.blk_id);
    r.granted_id = rq.blk_id;
    r.status = ST_OK;
    f = flags[id];
    case (rq.func)
      FN_ALLOC: begin
        r.granted_id = '0;
        ok = 1'b1;
        if (fifo_cnt == 0) begin
          h = lru_head;
          if (h >= NULL_ID) ok = 1'b0;
          else if (!flags[h][FB_CACHED] || !flags[h][FB_LRU] ||
                   flags[h][FB_FREE] || refs[h] != 0) ok = 1'b0;
          if (!ok) begin
            r.status = ST_EXHAUSTED;
          end else begin
            lru_remove(h);
            flags[h] = FLAGS_FREE; hashes[h] = '0;
            fifo_push(h);
            r.evicted = 1'b1; r.evicted_id = ID_W'(h);
          end
        end
        if (ok) begin
          g = fifo_ids[fifo_head % NB];
          if (g >= NB || flags[g] != FLAGS_FREE || refs[g] != 0 || hashes[g] != 0) begin
            r.status = ST_INCONSISTENT;
          end else begin
            fifo_head = (fifo_head + 1) % NB;
            fifo_cnt--;
            flags[g] = 3'b000; refs[g] = 1; hashes[g] = '0;
            r.granted_id = ID_W'(g);
          end
        end
      end
      FN_HIT: begin
        if (!f[FB_CACHED] || f[FB_FREE] || hashes[id] != rq.content_hash)
          r.status = ST_INCONSISTENT;
        else if (f[FB_LRU] && refs[id] == 0) begin
          lru_remove(id);
          flags[id][FB_LRU] = 1'b0;
          refs[id] = 1;
        end else if (!f[FB_LRU] && refs[id] > 0) begin
          if (refs[id] >= REF_TOP) r.status = ST_INCONSISTENT;
          else refs[id]++;
        end else r.status = ST_INCONSISTENT;
      end
      FN_MARK: begin
        if (refs[id] == 0 || f[FB_FREE] || f[FB_LRU]) r.status = ST_INCONSISTENT;
        else if (f[FB_CACHED]) begin
          if (hashes[id] != rq.content_hash) r.status = ST_INCONSISTENT;
        end else begin
          flags[id][FB_CACHED] = 1'b1;
          hashes[id] = rq.content_hash;
        end
      end
      default: begin
        if (f[FB_FREE]) r.status = ST_DOUBLE_FREE;
        else if (f[FB_LRU]) r.status = ST_INCONSISTENT;
        else if (refs[id] == 0) r.status = ST_DOUBLE_FREE;
        else begin
          refs[id]--;
          if (refs[id] == 0) begin
            if (f[FB_CACHED]) begin
              flags[id][FB_LRU] = 1'b1;
              lru_append(id);
            end else begin
              flags[id] = FLAGS_FREE; hashes[id] = '0;
              fifo_push(id);
            end
          end
        end
      end
    endcase
    r.free_count = CNT_W'(fifo_cnt);
    r.idle_count = CNT_W'(lru_cnt);
    return r;
  endfunction

  // Predict on input accept, compare on output accept
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      pool_reset();
      pending_rsp.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) pending_rsp = {pending_rsp, pool_serve(in_data_i)};
      if (out_valid_i && !out_stall_i) begin
        if (pending_rsp.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected response %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_rsp[0];
          pending_rsp.delete(0);
          if (want !== out_data_i) begin
            if (fail_count_o < 10)
              $display("mismatch: want %p got %p", want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= pending_rsp.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the block pool: directed corner requests, then random
// allocate/mark/hit/release traffic over a small random set of ids, with random
// idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rbpl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;
  int   fail_count;
  int   pending;
  bit   calm_phase = 1'b0;
  bit   hold_off = 1'b0;
  int   live_ids [$];
  logic [63:0] used_hash [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  refcounted_block_pool_lru_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  pool_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Send one request; idle gaps before it at random
  task automatic send_req(logic [1:0] fn, logic [9:0] id, logic [63:0] h);
    while (!calm_phase && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{func: fn, blk_id: id, content_hash: h};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [63:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  // Receiver stall pattern
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else out_stall_i <= !calm_phase && ($urandom_range(99) < 31);
    end
  end

  // Stimulus
  initial begin
    logic [63:0] h;
    int id, pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed corners
    send_req(FN_ALLOC, 10'h3ff, '1);
    send_req(FN_MARK, 10'd0, '1);
    send_req(FN_MARK, 10'd0, '1);
    send_req(FN_MARK, 10'd0, 64'd5);
    send_req(FN_HIT, 10'd0, '1);
    send_req(FN_HIT, 10'd0, 64'd1);
    send_req(FN_RELEASE, 10'd0, '0);
    send_req(FN_RELEASE, 10'd0, '0);
    send_req(FN_RELEASE, 10'd0, '0);
    send_req(FN_MARK, 10'd0, '0);
    send_req(FN_HIT, 10'd0, '1);
    send_req(FN_RELEASE, 10'd0, '0);
    send_req(FN_RELEASE, 10'd0, '0);
    send_req(FN_RELEASE, 10'd1023, '0);
    send_req(FN_HIT, 10'd512, '0);
    send_req(FN_MARK, 10'd1023, '0);
    send_req(FN_ALLOC, 10'd0, '0);
    // take the whole pool, then park a few blocks as cached idle so allocate evicts
    for (int i = 0; i < 1023; i++) send_req(FN_ALLOC, '0, '0);
    send_req(FN_ALLOC, '0, '0);
    for (int i = 1; i < 9; i++) begin
      send_req(FN_MARK, i[9:0], {54'h0, i[9:0]} ^ 64'hA5A5_0000_0000_0000);
      send_req(FN_RELEASE, i[9:0], '0);
    end
    send_req(FN_RELEASE, 10'd0, '0);
    send_req(FN_ALLOC, '0, '0);
    send_req(FN_HIT, 10'd5, 64'hA5A5_0000_0000_0005);
    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_req(FN_HIT, 10'd5, 64'hA5A5_0000_0000_0005);
    join
    for (int i = 0; i < 7; i++) send_req(FN_RELEASE, 10'd5, '0);
    // random traffic over a small working set
    for (int n = 0; n < 780; n++) begin
      calm_phase = (n >= 350 && n < 450);
      pick = $urandom_range(99);
      id = (live_ids.size() > 0) ? live_ids[$urandom_range(live_ids.size() - 1)]
                                 : $urandom_range(1023);
      h = (used_hash.size() > 0 && $urandom_range(3) != 0)
          ? used_hash[$urandom_range(used_hash.size() - 1)] : rand_hash();
      if (pick < 5) id = $urandom_range(1023);
      if (pick < 30) begin
        send_req(FN_ALLOC, 10'($urandom_range(1023)), rand_hash());
        if (live_ids.size() < 40) live_ids = {live_ids, int'($urandom_range(1023))};
      end else if (pick < 50) begin
        send_req(FN_MARK, 10'(id), h);
        if (used_hash.size() < 16) used_hash = {used_hash, h};
      end else if (pick < 75) begin
        send_req(FN_HIT, 10'(id), h);
      end else begin
        send_req(FN_RELEASE, 10'(id), rand_hash());
      end
    end
    calm_phase = 1'b0;
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
